FILE: hdl/olr_pkg.sv
// Package for the overwrite-oldest log ring: sizes, codes, item types and
// the index arithmetic used by the top level.
// No dependencies.
package olr_pkg;

  localparam int MaxDepth = 4096;
  localparam int IdxW     = $clog2(MaxDepth);
  localparam int LenW     = $clog2(MaxDepth + 1);
  localparam int MinLen   = 2;

  localparam logic OpAppend = 1'b0;
  localparam logic OpRead   = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]      read_byte;
    logic            read_ok;
    logic            dropped_oldest;
    logic [IdxW-1:0] available;
    logic [LenW-1:0] total_held;
  } out_item_t;

  typedef struct packed {
    logic            we;
    logic            re;
    logic [IdxW-1:0] addr;
    logic [7:0]      wdata;
  } store_req_t;

  // Step an index by one, wrap to zero at the ring length.
  function automatic logic [IdxW-1:0] advance(input logic [IdxW-1:0] idx,
                                              input logic [LenW-1:0] len);
    logic [LenW-1:0] sum;
    sum = {1'b0, idx} + LenW'(1);
    return (sum >= len) ? '0 : sum[IdxW-1:0];
  endfunction

  // Bytes between read and write index, wrapped by the ring length.
  function automatic logic [IdxW-1:0] fill_level(input logic [IdxW-1:0] wr,
                                                 input logic [IdxW-1:0] rd,
                                                 input logic [LenW-1:0] len);
    logic [LenW-1:0] diff;
    diff = {1'b0, wr} - {1'b0, rd};
    if (wr < rd) begin
      diff = diff + len;
    end
    return diff[IdxW-1:0];
  endfunction

endpackage

FILE: hdl/olr_store.sv
// Byte store of the log ring: one synchronous memory, one write or one read
// per cycle, read data registered. Depends on olr_pkg.
module olr_store (
  input  logic                clk_i,
  input  olr_pkg::store_req_t req_i,
  output logic [7:0]          rdata_o
);
  import olr_pkg::*;

  logic [7:0] mem [MaxDepth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/overwrite_oldest_log_ring_core.sv
// Top level of the overwrite-oldest log ring: index control, result register
// and the byte store. Depends on olr_pkg and olr_store.
//
// Usage:
// - Input channel (in_valid_i / in_stall_o / in_item_i): each transfer is one
//   append (op = append) or one read (op = read) of a single byte.
// - Output channel (out_valid_o / out_stall_i / out_item_o): exactly one
//   result per input transfer, in order.
// - Configuration: cfg_we_i writes cfg_wdata_i as the ring length, clamped to
//   2..4096; it clears both indices and the held total but keeps the bytes.
//   Write it only while no item is in flight.
// Timing: the result is valid in the cycle after the input
// transfer, and the next input is taken in the cycle after the result
// transfer, so no new item is taken before the last result is through.
// This comes from the one-item state machine around the store, whose read
// data arrives in the cycle after the address.
// Reset: indices and held total clear, the ring length returns to 4096, the
// store contents stay undefined until written.
// Receiver stall: the result holds in place and the input side stalls until
// the result transfer completes.
module overwrite_oldest_log_ring_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  olr_pkg::in_item_t                in_item_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output olr_pkg::out_item_t               out_item_o,
  input  logic                             cfg_we_i,
  input  logic [olr_pkg::LenW-1:0]         cfg_wdata_i
);
  import olr_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_OUT  = 2'b10
  } state_e;

  state_e          state_q, state_d;
  logic [IdxW-1:0] wr_idx_q, wr_idx_d;
  logic [IdxW-1:0] rd_idx_q, rd_idx_d;
  logic [LenW-1:0] held_q, held_d;
  logic [LenW-1:0] ring_len_q, ring_len_d;
  logic            read_ok_q, read_ok_d;
  logic            dropped_q, dropped_d;

  logic            in_xfer;
  logic            out_xfer;
  logic [IdxW-1:0] wr_next;
  logic [IdxW-1:0] rd_next;
  store_req_t      store_req;
  logic [7:0]      store_rdata;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_xfer = out_valid_o && !out_stall_i;
  assign wr_next  = advance(wr_idx_q, ring_len_q);
  assign rd_next  = advance(rd_idx_q, ring_len_q);

  always_comb begin
    state_d    = state_q;
    wr_idx_d   = wr_idx_q;
    rd_idx_d   = rd_idx_q;
    held_d     = held_q;
    ring_len_d = ring_len_q;
    read_ok_d  = read_ok_q;
    dropped_d  = dropped_q;
    store_req  = '{we: 1'b0, re: 1'b0, addr: wr_idx_q, wdata: in_item_i.data_byte};

    // Clamp the length and clear the indices and held total on a configuration write.
    if (cfg_we_i) begin
      if (cfg_wdata_i < LenW'(MinLen)) begin
        ring_len_d = LenW'(MinLen);
      end else if (cfg_wdata_i > LenW'(MaxDepth)) begin
        ring_len_d = LenW'(MaxDepth);
      end else begin
        ring_len_d = cfg_wdata_i;
      end
      wr_idx_d = '0;
      rd_idx_d = '0;
      held_d   = '0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d   = ST_OUT;
          read_ok_d = 1'b0;
          dropped_d = 1'b0;
          if (in_item_i.op == OpAppend) begin
            store_req.we = 1'b1;
            wr_idx_d     = wr_next;
            if (held_q < ring_len_q) begin
              held_d = held_q + LenW'(1);
            end
            // Drop the oldest byte when the write index catches up.
            if (rd_idx_q == wr_next) begin
              rd_idx_d  = rd_next;
              dropped_d = 1'b1;
            end
          end else if (rd_idx_q != wr_idx_q) begin
            store_req.re   = 1'b1;
            store_req.addr = rd_idx_q;
            rd_idx_d       = rd_next;
            read_ok_d      = 1'b1;
          end
        end
      end
      ST_OUT: begin
        if (out_xfer) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      wr_idx_q   <= '0;
      rd_idx_q   <= '0;
      held_q     <= '0;
      ring_len_q <= LenW'(MaxDepth);
      read_ok_q  <= 1'b0;
      dropped_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      wr_idx_q   <= wr_idx_d;
      rd_idx_q   <= rd_idx_d;
      held_q     <= held_d;
      ring_len_q <= ring_len_d;
      read_ok_q  <= read_ok_d;
      dropped_q  <= dropped_d;
    end
  end

  olr_store u_store (
    .clk_i   (clk_i),
    .req_i   (store_req),
    .rdata_o (store_rdata)
  );

  // The store's read register holds until the next read, so the payload
  // stays stable while the receiver stalls.
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_OUT);
  assign out_item_o  = '{
    read_byte:      read_ok_q ? store_rdata : 8'd0,
    read_ok:        read_ok_q,
    dropped_oldest: dropped_q,
    available:      fill_level(wr_idx_q, rd_idx_q, ring_len_q),
    total_held:     held_q
  };

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> out_valid_o)
    else $error("no result in the cycle after an input transfer");

  a_read_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.read_ok |-> !out_item_o.dropped_oldest)
    else $error("read result flags a dropped byte");

  a_avail_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, out_item_o.available} < ring_len_q))
    else $error("available count reaches the ring length");

  a_held_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q <= ring_len_q)
    else $error("held total exceeds the ring length");

endmodule
